// File: src/cvl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvl_pkg: shared types and constants of the compacting value list
// Operation and status codes, the default list depth and the control
// group that the top level hands to every cell of the row.
// ----------------------------------------------------------------------------
package cvl_pkg;

    localparam int CVL_DEPTH = 64;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_SEARCH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // Control common to all cells.
    typedef struct packed {
        logic capture;    // latch the select bit (acceptance cycle)
        logic read_mode;  // select on index hit rather than value match
        logic insert;     // update cycle of an insert
        logic remove;     // update cycle of a remove
    } cell_ctrl_t;

endpackage

// File: src/cvl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvl_cell: one position of the value list
// Holds one entry, compares it (or its index) with the request, latches
// a select bit; then loads an appended value or its right neighbor's entry.
// ----------------------------------------------------------------------------
module cvl_cell #(
    parameter int INDEX_W = 6,
    parameter int COUNT_W = 7,
    parameter int POS     = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cvl_pkg::cell_ctrl_t               ctrl,
    input  logic [COUNT_W-1:0]                count,
    input  logic signed [cvl_pkg::DATA_W-1:0] key,
    input  logic [INDEX_W-1:0]                idx,
    input  logic signed [cvl_pkg::DATA_W-1:0] load_value,
    input  logic                              after,
    input  logic signed [cvl_pkg::DATA_W-1:0] right_data,
    output logic signed [cvl_pkg::DATA_W-1:0] data,
    output logic                              sel
);
    import cvl_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic                     sel_reg;
    logic                     in_use;
    logic                     sel_next;

    assign in_use   = count > COUNT_W'(POS);
    assign sel_next = ctrl.read_mode ? (in_use && (idx == INDEX_W'(POS)))
                                     : (in_use && (data_reg == key));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            sel_reg <= sel_next;
        end
    end

    // A full list never loads: no cell sits at position count then.
    always_ff @(posedge clk)
    begin
        if (ctrl.insert && (count == COUNT_W'(POS)))
        begin
            data_reg <= load_value;
        end
        else if (ctrl.remove && after)
        begin
            data_reg <= right_data;
        end
    end

    assign data = data_reg;
    assign sel  = sel_reg;

endmodule

// File: src/compacting_value_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_value_list_unit: unordered list with insert, remove, read, search
// A row of cells holds the entries; every cell compares at once and a
// remove closes the gap by shifting all later cells left in one update.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------
//  request  | start / busy       | func, value, index
//  result   | done (one cycle)   | status, found_index, read_value, count
//
// A transaction is accepted at an edge with start high and busy low; the
// cells latch their compare result at that edge. The next cycle updates
// the row and registers the result, shown with done in the cycle after.
// A transaction is a compare followed by a row update.
// Reset clears the entry count; entries are not cleared and need no pass.
// The receiver cannot stall: done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module compacting_value_list_unit #(
    parameter int DEPTH   = cvl_pkg::CVL_DEPTH,
    parameter int INDEX_W = $clog2(DEPTH),
    parameter int COUNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  cvl_pkg::func_t                    func,
    input  logic signed [cvl_pkg::DATA_W-1:0] value,
    input  logic [INDEX_W-1:0]                index,
    output logic                              done,
    output cvl_pkg::status_t                  status,
    output logic [INDEX_W-1:0]                found_index,
    output logic signed [cvl_pkg::DATA_W-1:0] read_value,
    output logic [COUNT_W-1:0]                count
);
    import cvl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t                   state_reg;
    logic                     done_reg;
    func_t                    func_reg;
    logic signed [DATA_W-1:0] value_reg;
    status_t                  status_reg;
    logic [INDEX_W-1:0]       found_reg;
    logic signed [DATA_W-1:0] read_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic                     accept;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         sel;
    logic [DEPTH-1:0]         after;
    logic [DEPTH-1:0]         first;
    logic                     any_sel;
    logic                     full;
    logic [INDEX_W-1:0]       first_pos;
    logic signed [DATA_W-1:0] sel_data;

    assign accept = start && (state_reg == S_IDLE);

    assign ctrl.capture   = accept;
    assign ctrl.read_mode = (func == FUNC_READ);
    assign ctrl.insert    = (state_reg == S_APPLY) && (func_reg == FUNC_INSERT);
    assign ctrl.remove    = (state_reg == S_APPLY) && (func_reg == FUNC_REMOVE);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] right;
            if (g == DEPTH - 1)
            begin : g_last
                assign right = cell_data[g];
            end
            else
            begin : g_mid
                assign right = cell_data[g+1];
            end

            cvl_cell #(
                .INDEX_W(INDEX_W),
                .COUNT_W(COUNT_W),
                .POS    (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .count     (count_reg),
                .key       (value),
                .idx       (index),
                .load_value(value_reg),
                .after     (after[g]),
                .right_data(right),
                .data      (cell_data[g]),
                .sel       (sel[g])
            );
        end
    endgenerate

    // after[k] is set at and beyond the first selected cell.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            after[k] = |(sel & ({DEPTH{1'b1}} >> (DEPTH - 1 - k)));
        end
    end

    assign first   = sel & ~{after[DEPTH-2:0], 1'b0};
    assign any_sel = |sel;
    assign full    = (count_reg == COUNT_W'(DEPTH));

    always_comb
    begin
        first_pos = '0;
        sel_data  = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            first_pos = first_pos | ({INDEX_W{first[k]}} & INDEX_W'(k));
            sel_data  = sel_data | ({DATA_W{first[k]}} & cell_data[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            func_reg   <= FUNC_INSERT;
            value_reg  <= '0;
            status_reg <= ST_OK;
            found_reg  <= '0;
            read_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= func;
                        value_reg <= value;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    found_reg <= '0;
                    read_reg  <= '0;
                    unique case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                count_reg  <= count_reg + COUNT_W'(1);
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (any_sel)
                            begin
                                status_reg <= ST_OK;
                                found_reg  <= first_pos;
                                count_reg  <= count_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (any_sel)
                            begin
                                status_reg <= ST_OK;
                                read_reg   <= sel_data;
                            end
                            else
                            begin
                                status_reg <= ST_BAD_INDEX;
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            if (any_sel)
                            begin
                                status_reg <= ST_OK;
                                found_reg  <= first_pos;
                            end
                            else
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    assign busy        = (state_reg == S_APPLY);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign read_value  = read_reg;
    assign count       = count_reg;

    // A result strobe only follows an update cycle.
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_APPLY))
        else $error("result strobe without a preceding update cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // An index hit can select at most one cell.
    a_read_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && func_reg == FUNC_READ) |-> $onehot0(sel))
        else $error("read selected more than one cell");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && func_reg == FUNC_REMOVE && any_sel)
        |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("successful remove did not decrement the count");

    a_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && func_reg == FUNC_INSERT && full)
        |=> (status_reg == ST_FULL) && $stable(count_reg))
        else $error("insert into a full list changed the count");

endmodule

// File: tb/sv/compacting_value_list_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_value_list_unit_test: self-checking bench for the value list
// A driver sends insert, remove, read and search transactions from a queue,
// and a monitor predicts every result from its own copy of the list and
// checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module compacting_value_list_unit_test;

    import cvl_pkg::*;

    localparam int LIST_DEPTH = CVL_DEPTH;
    localparam int IDLE_LIMIT = 2000;
    localparam int SEND_GOAL  = 1600;

    typedef struct {
        func_t              func;
        logic signed [31:0] value;
        logic [5:0]         index;
        bit                 drain;
    } list_request_t;

    typedef struct {
        status_t            status;
        logic [5:0]         found_index;
        logic signed [31:0] read_value;
        logic [6:0]         count;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    func_t              func = FUNC_INSERT;
    logic signed [31:0] value = '0;
    logic [5:0]         index = '0;
    logic               done;
    status_t            status;
    logic [5:0]         found_index;
    logic signed [31:0] read_value;
    logic [6:0]         count;

    list_request_t      request_q[$];
    list_result_t       owed_results[$];
    logic signed [31:0] plan_vals[$];

    // Predicted contents of the list.
    logic signed [31:0] list_vals[LIST_DEPTH];
    int                 list_len = 0;

    logic               item_taken = 1'b0;
    int                 gap_left = 0;
    int                 burst_left = 0;
    int                 mismatches = 0;
    int                 idle_cycles = 0;

    compacting_value_list_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .value       (value),
        .index       (index),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .read_value  (read_value),
        .count       (count)
    );

    always #2 clk = ~clk;

    function automatic list_result_t apply_list_op(func_t op, logic signed [31:0] val,
                                                   logic [5:0] idx);
        list_result_t r;
        int           hit;
        hit = -1;
        r.status      = ST_OK;
        r.found_index = '0;
        r.read_value  = '0;
        for (int k = 0; k < list_len; k++)
        begin
            if (hit < 0 && list_vals[k] === val)
                hit = k;
        end
        case (op)
            FUNC_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    list_vals[list_len] = val;
                    list_len++;
                end
            end
            FUNC_REMOVE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int k = hit; k < list_len - 1; k++)
                        list_vals[k] = list_vals[k + 1];
                    list_len--;
                    r.found_index = hit[5:0];
                end
            end
            FUNC_READ:
            begin
                if (int'(idx) < list_len)
                    r.read_value = list_vals[idx];
                else
                    r.status = ST_BAD_INDEX;
            end
            default:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r.found_index = hit[5:0];
            end
        endcase
        r.count = list_len[6:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and occasional stretches with none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: a transaction stays on the ports until it is accepted.
    always @(negedge clk)
    begin
        list_request_t req;
        if (rst_n && !(start && !item_taken))
        begin
            if (start && item_taken)
                gap_left = pick_gap();
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (request_q.size() > 0 && request_q[0].drain)
            begin
                start <= 1'b0;
                if (owed_results.size() == 0)
                    void'(request_q.pop_front());
            end
            else if (request_q.size() > 0)
            begin
                req = request_q.pop_front();
                start <= 1'b1;
                func  <= req.func;
                value <= req.value;
                index <= req.index;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check the result shown in this cycle, then predict any new one.
    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result status=%0d found=%0d read=%0d count=%0d",
                                 $realtime, status, found_index, read_value, count);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (status !== want.status || found_index !== want.found_index ||
                        read_value !== want.read_value || count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch expected status=%0d found=%0d read=%0d ",
                                      "count=%0d, got status=%0d found=%0d read=%0d count=%0d"},
                                     $realtime, want.status, want.found_index, want.read_value,
                                     want.count, status, found_index, read_value, count);
                    end
                end
            end
            if (start && !busy)
                owed_results.push_back(apply_list_op(func, value, index));
            item_taken <= start && !busy;
        end
    end

    // Watchdog on cycles in which no transaction and no result is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Tracks what the list will hold, so that stimulus can pick present values.
    task automatic add_item(func_t f, logic signed [31:0] v, logic [5:0] idx);
        list_request_t req;
        int            hit;
        hit = -1;
        req.func  = f;
        req.value = v;
        req.index = idx;
        req.drain = 1'b0;
        request_q.push_back(req);
        if (f == FUNC_INSERT && plan_vals.size() < LIST_DEPTH)
            plan_vals.push_back(v);
        else if (f == FUNC_REMOVE)
        begin
            for (int k = 0; k < plan_vals.size(); k++)
            begin
                if (hit < 0 && plan_vals[k] === v)
                    hit = k;
            end
            if (hit >= 0)
                plan_vals.delete(hit);
        end
    endtask

    task automatic add_drain();
        list_request_t req;
        req.func  = FUNC_INSERT;
        req.value = '0;
        req.index = '0;
        req.drain = 1'b1;
        request_q.push_back(req);
    endtask

    function automatic logic signed [31:0] choose_value(int present_pct);
        logic signed [31:0] pool[8];
        int                 r;
        pool = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 2, 3, 32'sh5555_5555};
        r = $urandom_range(0, 99);
        if (plan_vals.size() > 0 && r < present_pct)
            return plan_vals[$urandom_range(0, plan_vals.size() - 1)];
        if (r < present_pct + (100 - present_pct) / 2)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [5:0] choose_index();
        if (plan_vals.size() > 0 && $urandom_range(0, 99) < 60)
            return 6'($urandom_range(0, plan_vals.size() - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    initial
    begin
        int    made;
        int    kind;
        int    span;
        int    next_drain;
        int    r;
        func_t f;

        // Empty list: nothing to read, find or remove.
        add_item(FUNC_READ, 0, 6'd0);
        add_item(FUNC_READ, 0, 6'd63);
        add_item(FUNC_SEARCH, 0, 6'd0);
        add_item(FUNC_REMOVE, 0, 6'd0);
        // Extremes of the value range and a duplicated value.
        add_item(FUNC_INSERT, 32'sh8000_0000, 6'd63);
        add_item(FUNC_INSERT, 32'sh7fff_ffff, 6'd0);
        add_item(FUNC_INSERT, 0, 6'd21);
        add_item(FUNC_INSERT, -1, 6'd42);
        add_item(FUNC_INSERT, 5, 6'd0);
        add_item(FUNC_INSERT, 5, 6'd0);
        add_item(FUNC_SEARCH, 5, 6'd0);
        add_item(FUNC_SEARCH, 32'sh7fff_ffff, 6'd63);
        add_item(FUNC_READ, 0, 6'd0);
        add_item(FUNC_READ, 0, 6'd5);
        add_item(FUNC_READ, 0, 6'd6);
        add_item(FUNC_READ, 0, 6'd63);
        add_item(FUNC_REMOVE, 5, 6'd0);
        add_item(FUNC_SEARCH, 5, 6'd0);
        // Removing the head shifts every later entry.
        add_item(FUNC_REMOVE, 32'sh8000_0000, 6'd0);
        add_item(FUNC_READ, 0, 6'd0);
        add_item(FUNC_REMOVE, 5, 6'd0);
        add_item(FUNC_REMOVE, 5, 6'd0);
        add_item(FUNC_SEARCH, -1, 6'd0);
        add_drain();

        made = 0;
        next_drain = 400;
        kind = 0;
        while (made < SEND_GOAL)
        begin
            // Fill runs into the full list, drain empties it, mixed is anything.
            if (kind == 0)
                span = LIST_DEPTH - plan_vals.size() + $urandom_range(2, 8);
            else if (kind == 1)
                span = plan_vals.size() + $urandom_range(2, 6);
            else
                span = $urandom_range(30, 80);
            for (int n = 0; n < span; n++)
            begin
                r = $urandom_range(0, 99);
                if (kind == 0)
                    f = (r < 85) ? FUNC_INSERT : func_t'($urandom_range(0, 3));
                else if (kind == 1)
                    f = (r < 70) ? FUNC_REMOVE : ((r < 85) ? FUNC_READ : FUNC_SEARCH);
                else
                    f = func_t'($urandom_range(0, 3));
                add_item(f, choose_value((kind == 1) ? 85 : 45), choose_index());
                made++;
            end
            if (made >= next_drain)
            begin
                add_drain();
                next_drain += 400;
            end
            kind = $urandom_range(0, 2);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() > 0 || start || owed_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
